// ----- src/qdsp_pkg.sv -----
// Package for the QR data segment packer.
// Holds the command, mode and register codes, the shared structs and the
// character decode and count-width helper functions. No dependencies.
package qdsp_pkg;

    // Request commands.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    // Coding modes.
    localparam logic [1:0] MODE_NUMERIC = 2'd0;
    localparam logic [1:0] MODE_ALNUM   = 2'd1;
    localparam logic [1:0] MODE_BYTE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_DCC     = 2'd2;

    // Register reset values.
    localparam logic [1:0]  MODE_RESET    = MODE_BYTE;
    localparam logic [5:0]  VERSION_RESET = 6'd0;
    localparam logic [11:0] DCC_RESET     = 12'd19;

    // Pad codewords and terminator length.
    localparam logic [7:0] PAD_FIRST  = 8'hEC;
    localparam logic [7:0] PAD_SECOND = 8'h11;
    localparam logic [2:0] TERM_BITS  = 3'd4;

    // Result queue depth.
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] char_count;
        logic [7:0]  char_code;
    } qdsp_item_t;

    typedef struct packed {
        logic [1:0]  coding_mode;
        logic [5:0]  symbol_version;
        logic [11:0] data_codeword_count;
    } qdsp_cfg_t;

    typedef struct packed {
        logic [7:0] codeword;
        logic       last;
        logic       bad_char;
    } qdsp_result_t;

    // Up to two results written into the queue in one cycle, packed low.
    typedef struct packed {
        logic [1:0]   n;
        qdsp_result_t first;
        qdsp_result_t second;
    } qdsp_push_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } qdsp_char_t;

    // Version tier: 0 for versions below 9, 1 up to 25, 2 above.
    function automatic logic [1:0] version_tier(input logic [5:0] version);
        logic [1:0] t;
        if (version < 6'd9)
            t = 2'd0;
        else if (version < 6'd26)
            t = 2'd1;
        else
            t = 2'd2;
        return t;
    endfunction

    // Width of the character count field.
    function automatic logic [4:0] count_bits(input logic [1:0] mode, input logic [1:0] tier);
        logic [4:0] w;
        case (mode)
            MODE_NUMERIC: w = (tier == 2'd0) ? 5'd10 : ((tier == 2'd1) ? 5'd12 : 5'd14);
            MODE_ALNUM:   w = (tier == 2'd0) ? 5'd9  : ((tier == 2'd1) ? 5'd11 : 5'd13);
            default:      w = (tier == 2'd0) ? 5'd8  : 5'd16;
        endcase
        return w;
    endfunction

    // Decimal digit decode; anything else is invalid and reads as zero.
    function automatic qdsp_char_t digit_decode(input logic [7:0] c);
        qdsp_char_t r;
        r.ok    = 1'b0;
        r.value = 6'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.ok    = 1'b1;
            r.value = 6'(c - 8'h30);
        end
        return r;
    endfunction

    // Alphanumeric decode over the 45-symbol set.
    function automatic qdsp_char_t alnum_decode(input logic [7:0] c);
        qdsp_char_t r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h30:8'h39]})
            r.value = 6'(c - 8'h30);
        else if (c inside {[8'h41:8'h5A]})
            r.value = 6'(c - 8'h41 + 8'd10);
        else
        begin
            case (c)
                8'h20:   r.value = 6'd36;
                8'h24:   r.value = 6'd37;
                8'h25:   r.value = 6'd38;
                8'h2A:   r.value = 6'd39;
                8'h2B:   r.value = 6'd40;
                8'h2D:   r.value = 6'd41;
                8'h2E:   r.value = 6'd42;
                8'h2F:   r.value = 6'd43;
                8'h3A:   r.value = 6'd44;
                default: r.ok = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- src/qr_data_segment_packer_unit.sv -----
// Top level of the QR data segment packer: request register, configuration
// registers, packing core and result queue.
// Depends on qdsp_pkg, qdsp_pack_core and qdsp_result_fifo.
//
// Usage:
//   Requests arrive on req_valid/req_ready with command, char_count and
//   char_code. A start request emits the mode indicator and count field,
//   character requests pack characters, and each drain request emits one
//   closing codeword (terminator, zero fill or pad).
//   Codewords leave on cw_valid/cw_ready with codeword, last and bad_char.
//   A request causes zero, one or two codewords.
//   An accepted request waits in the request register until the queue has
//   room; it is then processed and its codewords go into the result queue.
//   Throughput: one request per cycle while the result queue has room for two
//   more codewords. The queue drains one codeword per cycle, so requests that
//   yield two codewords hold back the requests behind them.
//   Configuration registers are written through cfg_write/cfg_index/cfg_data;
//   the user must write them only while no request is in flight (not enforced).
//   Reset clears all packing state, empties the queue and sets byte mode,
//   version index 0 and 19 data codewords.
//   When the receiver stalls, codewords wait in a four-entry queue; once it
//   lacks room for two more, the request register holds and req_ready drops.
module qr_data_segment_packer_unit
    import qdsp_pkg::*;
#(
    parameter int MAX_DATA_CODEWORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  command,
    input  logic [12:0] char_count,
    input  logic [7:0]  char_code,
    output logic        cw_valid,
    input  logic        cw_ready,
    output logic [7:0]  codeword,
    output logic        last,
    output logic        bad_char,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    qdsp_cfg_t    cfg_reg;
    qdsp_item_t   item_reg;
    logic         item_valid_reg;
    logic         fire;
    logic [2:0]   level;
    qdsp_push_t   push;
    qdsp_result_t head;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coding_mode         <= MODE_RESET;
            cfg_reg.symbol_version      <= VERSION_RESET;
            cfg_reg.data_codeword_count <= DCC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:    cfg_reg.coding_mode         <= cfg_data[1:0];
                CFG_VERSION: cfg_reg.symbol_version      <= cfg_data[5:0];
                CFG_DCC:     cfg_reg.data_codeword_count <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Request register: processed when the queue has room for two results.
    assign fire      = item_valid_reg && (level <= 3'(RES_DEPTH - 2));
    assign req_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req_ready)
            item_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.command    <= command;
            item_reg.char_count <= char_count;
            item_reg.char_code  <= char_code;
        end
    end

    qdsp_pack_core #(
        .MAX_DATA_CODEWORDS(MAX_DATA_CODEWORDS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .push  (push)
    );

    qdsp_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (cw_valid && cw_ready),
        .head  (head),
        .level (level)
    );

    // Result channel.
    assign cw_valid = level != 3'd0;
    assign codeword = head.codeword;
    assign last     = head.last;
    assign bad_char = head.bad_char;

endmodule

// ----- src/qdsp_result_fifo.sv -----
// Small result queue for the QR data segment packer.
// Takes up to two results per cycle and gives one per cycle.
// Depends on qdsp_pkg.
module qdsp_result_fifo
    import qdsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qdsp_push_t   push,
    input  logic         pop,
    output qdsp_result_t head,
    output logic [2:0]   level
);

    qdsp_result_t mem [RES_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] level_reg, level_next;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        level_next  = level_reg + {1'b0, push.n} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage writes; the second result goes into the following slot.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.n == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push.second;
    end

    assign head  = mem[rd_ptr_reg];
    assign level = level_reg;

    // The queue never holds more than its depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= 3'(RES_DEPTH))
        else $error("result queue over its depth");

    // A push only happens with room for two results.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> level_reg <= 3'(RES_DEPTH - 2))
        else $error("result pushed without room");

endmodule

// ----- src/qdsp_pack_core.sv -----
// Packing core of the QR data segment packer: holds the bit accumulator,
// the character grouping and the closing-codeword state.
// Depends on qdsp_pkg.
module qdsp_pack_core
    import qdsp_pkg::*;
#(
    parameter int MAX_DATA_CODEWORDS = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  qdsp_item_t item,
    input  qdsp_cfg_t  cfg,
    output qdsp_push_t push
);

    localparam int DONE_W = $clog2(MAX_DATA_CODEWORDS + 1);
    localparam logic [12:0] MAX_LIM = 13'(MAX_DATA_CODEWORDS);

    logic [7:0]        partial_reg, partial_next;
    logic [2:0]        pos_reg, pos_next;
    logic [DONE_W-1:0] done_reg, done_next;
    logic [12:0]       chars_left_reg, chars_left_next;
    logic [6:0]        held_val_reg, held_val_next;
    logic [1:0]        held_size_reg, held_size_next;
    logic [2:0]        term_reg, term_next;
    logic              pad_toggle_reg, pad_toggle_next;
    logic              err_reg, err_next;

    logic [12:0] lim;
    logic [12:0] done_ext;
    logic [1:0]  mode_idx;
    qdsp_char_t  dv;
    qdsp_char_t  av;
    logic [10:0] num_acc;
    logic [12:0] aln_acc;
    logic [4:0]  cbits;
    logic [3:0]  indicator;
    logic [7:0]  base_partial;
    logic [2:0]  base_pos;
    logic [12:0] base_done;
    logic [19:0] put_val;
    logic [4:0]  put_n;
    logic [4:0]  shamt;
    logic [4:0]  total;
    logic [23:0] win;
    logic [3:0]  room;
    logic        e0;
    logic        e1;
    qdsp_push_t  push_c;

    // Effective codeword limit and shared decodes.
    always_comb
    begin
        lim       = ({1'b0, cfg.data_codeword_count} > MAX_LIM) ? MAX_LIM
                                                               : {1'b0, cfg.data_codeword_count};
        done_ext  = 13'(done_reg);
        mode_idx  = (cfg.coding_mode == 2'd3) ? MODE_BYTE : cfg.coding_mode;
        dv        = digit_decode(item.char_code);
        av        = alnum_decode(item.char_code);
        num_acc   = 11'(held_val_reg) * 11'd10 + 11'(dv.value);
        aln_acc   = 13'(held_val_reg) * 13'd45 + 13'(av.value);
        cbits     = count_bits(mode_idx, version_tier(cfg.symbol_version));
        indicator = 4'b0001 << mode_idx;
    end

    // Per-command state update and bit packing.
    always_comb
    begin
        partial_next    = partial_reg;
        pos_next        = pos_reg;
        done_next       = done_reg;
        chars_left_next = chars_left_reg;
        held_val_next   = held_val_reg;
        held_size_next  = held_size_reg;
        term_next       = term_reg;
        pad_toggle_next = pad_toggle_reg;
        err_next        = err_reg;
        base_partial    = partial_reg;
        base_pos        = pos_reg;
        base_done       = done_ext;
        put_val         = '0;
        put_n           = '0;
        room            = 4'd8 - {1'b0, pos_reg};
        push_c          = '0;

        // Command decode: choose the bits to append.
        case (item.command)
            CMD_START:
            begin
                base_partial    = '0;
                base_pos        = '0;
                base_done       = '0;
                chars_left_next = item.char_count;
                held_val_next   = '0;
                held_size_next  = '0;
                term_next       = TERM_BITS;
                pad_toggle_next = 1'b0;
                err_next        = 1'b0;
                put_val = (20'(indicator) << cbits)
                        | (20'(item.char_count) & ((20'd1 << cbits) - 20'd1));
                put_n   = 5'd4 + cbits;
            end
            CMD_CHAR:
            begin
                if (chars_left_reg != 13'd0)
                begin
                    chars_left_next = chars_left_reg - 13'd1;
                    case (mode_idx)
                        MODE_NUMERIC:
                        begin
                            if (!dv.ok)
                                err_next = 1'b1;
                            if (held_size_reg >= 2'd2)
                            begin
                                put_val        = 20'(num_acc[9:0]);
                                put_n          = 5'd10;
                                held_val_next  = '0;
                                held_size_next = '0;
                            end
                            else if (chars_left_reg == 13'd1)
                            begin
                                // Trailing pair or single digit closes the segment.
                                put_val        = 20'(num_acc[6:0]);
                                put_n          = (held_size_reg == 2'd1) ? 5'd7 : 5'd4;
                                held_val_next  = '0;
                                held_size_next = '0;
                            end
                            else
                            begin
                                held_val_next  = num_acc[6:0];
                                held_size_next = held_size_reg + 2'd1;
                            end
                        end
                        MODE_ALNUM:
                        begin
                            if (!av.ok)
                                err_next = 1'b1;
                            if (held_size_reg != 2'd0)
                            begin
                                put_val        = 20'(aln_acc[10:0]);
                                put_n          = 5'd11;
                                held_val_next  = '0;
                                held_size_next = '0;
                            end
                            else if (chars_left_reg == 13'd1)
                            begin
                                put_val        = 20'(av.value);
                                put_n          = 5'd6;
                                held_val_next  = '0;
                                held_size_next = '0;
                            end
                            else
                            begin
                                held_val_next  = 7'(av.value);
                                held_size_next = 2'd1;
                            end
                        end
                        default:
                        begin
                            put_val = 20'(item.char_code);
                            put_n   = 5'd8;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        // Append the bits MSB first into a 24-bit window.
        shamt = 5'd24 - 5'(base_pos) - put_n;
        total = 5'(base_pos) + put_n;
        win   = {base_partial, 16'd0} | (24'(put_val) << shamt);
        e0    = (total[4:3] != 2'd0) && (base_done < lim);
        e1    = (total[4:3] == 2'd2) && ((base_done + 13'd1) < lim);
        pos_next = total[2:0];
        case (total[4:3])
            2'd0:    partial_next = win[23:16];
            2'd1:    partial_next = win[15:8];
            default: partial_next = win[7:0];
        endcase
        push_c.n               = {1'b0, e0} + {1'b0, e1};
        push_c.first.codeword  = win[23:16];
        push_c.first.last      = (base_done + 13'd1) == lim;
        push_c.first.bad_char  = err_next;
        push_c.second.codeword = win[15:8];
        push_c.second.last     = (base_done + 13'd2) == lim;
        push_c.second.bad_char = err_next;
        done_next = DONE_W'(base_done + 13'(push_c.n));

        // Drain tick: one closing codeword, terminator first, then pads.
        if (item.command == CMD_DRAIN)
        begin
            push_c = '0;
            if (done_ext < lim)
            begin
                push_c.n              = 2'd1;
                push_c.first.last     = (done_ext + 13'd1) == lim;
                push_c.first.bad_char = err_reg;
                done_next             = DONE_W'(done_ext + 13'd1);
                partial_next          = '0;
                pos_next              = '0;
                if (pos_reg != 3'd0)
                begin
                    push_c.first.codeword = partial_reg;
                    term_next = ({1'b0, term_reg} > room) ? 3'({1'b0, term_reg} - room) : 3'd0;
                end
                else if (term_reg != 3'd0)
                begin
                    push_c.first.codeword = 8'd0;
                    term_next = 3'd0;
                end
                else
                begin
                    push_c.first.codeword = pad_toggle_reg ? PAD_SECOND : PAD_FIRST;
                    pad_toggle_next = ~pad_toggle_reg;
                end
            end
        end
    end

    assign push = fire ? push_c : '0;

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            pos_reg        <= '0;
            done_reg       <= '0;
            chars_left_reg <= '0;
            held_val_reg   <= '0;
            held_size_reg  <= '0;
            term_reg       <= TERM_BITS;
            pad_toggle_reg <= 1'b0;
            err_reg        <= 1'b0;
        end
        else if (fire)
        begin
            partial_reg    <= partial_next;
            pos_reg        <= pos_next;
            done_reg       <= done_next;
            chars_left_reg <= chars_left_next;
            held_val_reg   <= held_val_next;
            held_size_reg  <= held_size_next;
            term_reg       <= term_next;
            pad_toggle_reg <= pad_toggle_next;
            err_reg        <= err_next;
        end
    end

    // At most two characters are ever held back.
    a_held_size: assert property (@(posedge clk) disable iff (!rst_n)
        held_size_reg <= 2'd2)
        else $error("held group too large");

    // The final codeword can only be the later one of a pair.
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> !push.first.last)
        else $error("final codeword followed by another");

    // After the final codeword the count sits at the limit.
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd1 && push.first.last) || (push.n == 2'd2 && push.second.last)
        |=> done_ext == $past(lim))
        else $error("codeword count off after final codeword");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for qr_data_segment_packer_unit: directed segments
// and random segments under four flow-control mixes, checked per codeword.
// Depends on qdsp_pkg and the packer RTL under src.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import qdsp_pkg::*;

    localparam int DATA_CW_MAX = 4096;

    // Clock, reset and block ports.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_valid  = 1'b0;
    logic        req_ready;
    logic [1:0]  command    = CMD_START;
    logic [12:0] char_count = 13'd0;
    logic [7:0]  char_code  = 8'd0;
    logic        cw_valid;
    logic        cw_ready   = 1'b1;
    logic [7:0]  codeword;
    logic        last;
    logic        bad_char;
    logic        cfg_write  = 1'b0;
    logic [1:0]  cfg_index  = CFG_MODE;
    logic [11:0] cfg_data   = 12'd0;

    // Flow-control knobs, in percent.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Run statistics.
    int fail_count        = 0;
    int requests_sent     = 0;
    int effective_sent    = 0;
    int codewords_checked = 0;

    // Packer model: registers and packing state.
    logic [1:0]  mode_reg    = MODE_RESET;
    logic [5:0]  version_reg = VERSION_RESET;
    logic [11:0] dcc_reg     = DCC_RESET;
    logic [7:0]  acc_byte    = 8'd0;
    int          acc_bits    = 0;
    logic [11:0] cw_done     = 12'd0;
    logic [12:0] chars_left  = 13'd0;
    logic [6:0]  held_value  = 7'd0;
    logic [1:0]  held_size   = 2'd0;
    logic [2:0]  term_left   = TERM_BITS;
    logic        pad_odd     = 1'b0;
    logic        err_flag    = 1'b0;
    int          step_count  = 0;

    // The 45 alphanumeric symbols in value order.
    string alnum_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

    // Codewords predicted but not yet seen, oldest first.
    qdsp_result_t expected_cw[$];

    qr_data_segment_packer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .char_count(char_count),
        .char_code (char_code),
        .cw_valid  (cw_valid),
        .cw_ready  (cw_ready),
        .codeword  (codeword),
        .last      (last),
        .bad_char  (bad_char),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Number of codewords the symbol can hold.
    function automatic int cw_capacity();
        return (dcc_reg > DATA_CW_MAX) ? DATA_CW_MAX : int'(dcc_reg);
    endfunction

    // Mode 3 behaves as byte mode.
    function automatic logic [1:0] active_mode();
        return (mode_reg >= MODE_BYTE) ? MODE_BYTE : mode_reg;
    endfunction

    // Queue one finished codeword unless the symbol is full or this request already queued two.
    function automatic void push_codeword(input logic [7:0] value);
        qdsp_result_t r;
        if (int'(cw_done) >= cw_capacity() || step_count >= 2)
            return;
        r.codeword = value;
        r.last     = (int'(cw_done) + 1 == cw_capacity());
        r.bad_char = err_flag;
        expected_cw.push_back(r);
        step_count++;
        cw_done = cw_done + 12'd1;
    endfunction

    // Shift the low nbits of value into the byte accumulator, MSB first.
    function automatic void shift_in(input logic [15:0] value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
        begin
            acc_byte[7 - acc_bits] = value[i];
            acc_bits++;
            if (acc_bits == 8)
            begin
                push_codeword(acc_byte);
                acc_byte = 8'd0;
                acc_bits = 0;
            end
        end
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        err_flag = 1'b1;
        return 0;
    endfunction

    function automatic int alnum_of(input logic [7:0] c);
        for (int i = 0; i < alnum_set.len(); i++)
        begin
            if (alnum_set[i] == c)
                return i;
        end
        err_flag = 1'b1;
        return 0;
    endfunction

    // Start of a segment: mode indicator and character count field.
    function automatic void start_segment(input logic [12:0] count);
        logic [1:0] m;
        int         tier;
        int         width;
        m    = active_mode();
        tier = (version_reg < 9) ? 0 : ((version_reg < 26) ? 1 : 2);
        case (m)
            MODE_NUMERIC: width = 10 + 2 * tier;
            MODE_ALNUM:   width = 9 + 2 * tier;
            default:      width = (tier == 0) ? 8 : 16;
        endcase
        acc_byte   = 8'd0;
        acc_bits   = 0;
        cw_done    = 12'd0;
        chars_left = count;
        held_value = 7'd0;
        held_size  = 2'd0;
        term_left  = TERM_BITS;
        pad_odd    = 1'b0;
        err_flag   = 1'b0;
        shift_in(16'd1 << m, 4);
        shift_in(16'(count), width);
    endfunction

    // One character under the mode in force, with the held group as it stands.
    function automatic void pack_char(input logic [7:0] c);
        logic [1:0] m;
        int         v;
        m = active_mode();
        chars_left = chars_left - 13'd1;
        case (m)
            MODE_NUMERIC:
            begin
                v = digit_of(c);
                if (held_size >= 2)
                begin
                    shift_in(16'(held_value * 10 + v), 10);
                    held_value = 7'd0;
                    held_size  = 2'd0;
                end
                else
                begin
                    held_value = 7'(held_value * 10 + v);
                    held_size  = held_size + 2'd1;
                end
                if (chars_left == 0 && held_size != 0)
                begin
                    shift_in(16'(held_value), (held_size == 2) ? 7 : 4);
                    held_value = 7'd0;
                    held_size  = 2'd0;
                end
            end
            MODE_ALNUM:
            begin
                v = alnum_of(c);
                if (held_size != 0)
                begin
                    shift_in(16'(held_value * 45 + v), 11);
                    held_value = 7'd0;
                    held_size  = 2'd0;
                end
                else
                begin
                    held_value = 7'(v);
                    held_size  = 2'd1;
                end
                if (chars_left == 0 && held_size != 0)
                begin
                    shift_in(16'(held_value), 6);
                    held_value = 7'd0;
                    held_size  = 2'd0;
                end
            end
            default: shift_in(16'(c), 8);
        endcase
    endfunction

    // One closing codeword: zero fill with terminator, bare terminator, or pad.
    function automatic void drain_tick();
        int room;
        if (acc_bits != 0)
        begin
            room      = 8 - acc_bits;
            term_left = (term_left > room) ? 3'(term_left - room) : 3'd0;
            push_codeword(acc_byte);
            acc_byte = 8'd0;
            acc_bits = 0;
        end
        else if (term_left != 0)
        begin
            term_left = 3'd0;
            push_codeword(8'h00);
        end
        else
        begin
            push_codeword(pad_odd ? PAD_SECOND : PAD_FIRST);
            pad_odd = ~pad_odd;
        end
    endfunction

    // Predict the codewords of one accepted request; returns 0 if it is ignored.
    function automatic bit pack_request(input logic [1:0] cmd, input logic [12:0] count,
                                        input logic [7:0] code);
        bit effective;
        effective  = 1'b0;
        step_count = 0;
        case (cmd)
            CMD_START:
            begin
                start_segment(count);
                effective = 1'b1;
            end
            CMD_CHAR:
            begin
                if (chars_left != 0)
                begin
                    pack_char(code);
                    effective = 1'b1;
                end
            end
            CMD_DRAIN:
            begin
                if (int'(cw_done) < cw_capacity())
                begin
                    drain_tick();
                    effective = 1'b1;
                end
            end
            default: effective = 1'b0;
        endcase
        return effective;
    endfunction

    // Send one request, with random idle cycles ahead of it.
    task automatic send_request(input logic [1:0] cmd, input logic [12:0] count,
                                input logic [7:0] code);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        command    <= cmd;
        char_count <= count;
        char_code  <= code;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (pack_request(cmd, count, code))
            effective_sent++;
        requests_sent++;
    endtask

    // Stop sending, let every predicted codeword arrive, then cover the latency.
    task automatic settle();
        req_valid <= 1'b0;
        while (expected_cw.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MODE:    mode_reg    = value[1:0];
            CFG_VERSION: version_reg = value[5:0];
            CFG_DCC:     dcc_reg     = value;
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] m, input logic [5:0] version,
                             input logic [11:0] dcc);
        settle();
        write_register(CFG_MODE, 12'(m));
        write_register(CFG_VERSION, 12'(version));
        write_register(CFG_DCC, dcc);
    endtask

    // A character for the given mode, legal unless asked otherwise.
    function automatic logic [7:0] pick_char(input logic [1:0] m, input bit legal);
        if (!legal)
            return 8'($urandom_range(255));
        case (m)
            MODE_NUMERIC: return 8'(8'h30 + $urandom_range(9));
            MODE_ALNUM:   return 8'(alnum_set[$urandom_range(44)]);
            default:      return 8'($urandom_range(255));
        endcase
    endfunction

    // Reset registers: byte mode, short count field, 19 codewords.
    task automatic test_byte_segment();
        send_request(CMD_START, 13'd2, 8'h00);
        send_request(CMD_CHAR, 13'd0, 8'h00);
        send_request(CMD_CHAR, 13'h1FFF, 8'hFF);
        send_request(CMD_DRAIN, 13'd0, 8'h00);
    endtask

    // Digit group, invalid trailing digit, extra character, terminator, pad, full symbol.
    task automatic test_numeric_groups();
        configure(MODE_NUMERIC, 6'd39, 12'd6);
        send_request(CMD_START, 13'd4, 8'h00);
        send_request(CMD_CHAR, 13'd0, 8'h30);
        send_request(CMD_CHAR, 13'd0, 8'h39);
        send_request(CMD_CHAR, 13'd0, 8'h39);
        send_request(CMD_CHAR, 13'd0, 8'h58);
        send_request(CMD_CHAR, 13'd0, 8'h37);
        repeat (3) send_request(CMD_DRAIN, 13'd0, 8'h00);
    endtask

    // Alphanumeric pair and trailing single at a codeword count of 2956.
    task automatic test_alnum_pairs();
        configure(MODE_ALNUM, 6'd9, 12'd2956);
        send_request(CMD_START, 13'd3, 8'h00);
        send_request(CMD_CHAR, 13'd0, 8'h5A);
        send_request(CMD_CHAR, 13'd0, 8'h3A);
        send_request(CMD_CHAR, 13'd0, 8'h25);
        repeat (2) send_request(CMD_DRAIN, 13'd0, 8'h00);
    endtask

    // Mode 3, single-codeword symbol, unknown command, oversized count,
    // version past the table, and a mode switch in the middle of a segment.
    task automatic test_corner_cases();
        configure(2'd3, 6'd26, 12'd1);
        send_request(CMD_START, 13'd5, 8'h00);
        send_request(CMD_DRAIN, 13'd0, 8'h00);
        send_request(2'd3, 13'h1FFF, 8'hFF);
        configure(MODE_NUMERIC, 6'd0, 12'd3);
        send_request(CMD_START, 13'd7089, 8'h00);
        configure(MODE_ALNUM, 6'd63, 12'd8);
        send_request(CMD_START, 13'd3, 8'h00);
        send_request(CMD_CHAR, 13'd0, 8'h41);
        configure(MODE_NUMERIC, 6'd63, 12'd8);
        send_request(CMD_CHAR, 13'd0, 8'h35);
        configure(MODE_ALNUM, 6'd63, 12'd8);
        send_request(CMD_CHAR, 13'd0, 8'h42);
    endtask

    // Random segments: mostly well-formed, some bad characters, extras and noise.
    task automatic run_segments(input int item_goal, input int sender_idle,
                                input int receiver_stall);
        int         goal_end;
        int         count;
        int         n_chars;
        int         drains;
        logic [1:0] m;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        goal_end  = effective_sent + item_goal;
        while (effective_sent < goal_end)
        begin
            if ($urandom_range(3) == 0)
                configure(($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)),
                          6'($urandom_range(63)),
                          ($urandom_range(4) == 0) ? 12'($urandom_range(1, 4095))
                                                   : 12'($urandom_range(1, 40)));
            if ($urandom_range(9) == 0)
            begin
                send_request(2'($urandom_range(3)), 13'($urandom_range(7089)),
                             8'($urandom_range(255)));
            end
            else
            begin
                count = ($urandom_range(6) == 0) ? $urandom_range(25, 7089)
                                                 : $urandom_range(0, 24);
                send_request(CMD_START, 13'(count), 8'($urandom_range(255)));
                n_chars = (count > 40) ? 40 : count;
                if ($urandom_range(9) == 0)
                    n_chars += $urandom_range(1, 2);
                m = active_mode();
                for (int i = 0; i < n_chars; i++)
                    send_request(CMD_CHAR, 13'($urandom_range(8191)),
                                 pick_char(m, $urandom_range(14) != 0));
                drains = 0;
                while (int'(cw_done) < cw_capacity() && drains < 48)
                begin
                    send_request(CMD_DRAIN, 13'($urandom_range(8191)),
                                 8'($urandom_range(255)));
                    drains++;
                end
                if ($urandom_range(3) == 0)
                    send_request(CMD_DRAIN, 13'd0, 8'h00);
            end
        end
        settle();
    endtask

    // Receiver: random stalls at the rate of the current phase.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cw_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each delivered codeword with the oldest prediction.
    always @(posedge clk)
    begin : check_codewords
        qdsp_result_t want;
        if (rst_n && cw_valid && cw_ready)
        begin
            if (expected_cw.size() == 0)
            begin
                $error("codeword %h arrived with no request pending", codeword);
                fail_count++;
            end
            else
            begin
                want = expected_cw.pop_front();
                codewords_checked++;
                if (codeword !== want.codeword)
                begin
                    $error("codeword: expected %h, got %h", want.codeword, codeword);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    fail_count++;
                end
                if (bad_char !== want.bad_char)
                begin
                    $error("bad_char: expected %b, got %b", want.bad_char, bad_char);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_byte_segment();
        test_numeric_groups();
        test_alnum_pairs();
        test_corner_cases();
        run_segments(325, 0, 0);
        run_segments(325, 79, 0);
        run_segments(325, 0, 79);
        run_segments(325, 13, 13);
        settle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d requests (%0d that packed or drained) and %0d codewords",
                 requests_sent, effective_sent, codewords_checked);
        $display("in numeric, alphanumeric and byte modes under four flow-control mixes.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- qr_data_segment_packer_unit.f -----
src/qdsp_pkg.sv
src/qdsp_result_fifo.sv
src/qdsp_pack_core.sv
src/qr_data_segment_packer_unit.sv
sim/testbench.sv
